/* design/fmop_pkg.sv */
// Shared types and constants for the two-operator FM voice.
// Holds the controller/datapath command and status structs, register indexes
// and the sine table entry function. No dependencies.
package fmop_pkg;

    localparam int ENV_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 32;
    localparam int DEPTH_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULATOR_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_CARRIER = 3'd4;

    localparam logic [STEP_W-1:0]  CARRIER_STEP_RST   = 32'd39370534;
    localparam logic [STEP_W-1:0]  MODULATOR_STEP_RST = 32'd39370534;
    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST      = 16'sd0;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST      = 16'sd8192;

    localparam logic [63:0] Q30        = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Operand pairs of the shared multiplier
    typedef enum logic [1:0] {
        MUL_DEPTH = 2'd0,   // (max - min) * modulation envelope
        MUL_MSD   = 2'd1,   // modulator sine * depth
        MUL_STEP  = 2'd2,   // modulator step * (sine * depth)
        MUL_OUT   = 2'd3    // carrier envelope * carrier sine
    } mul_sel_t;

    typedef struct packed {
        logic     load;         // request accepted: latch inputs, advance modulator
        logic     rom_rd;       // read sine table
        logic     rom_carrier;  // address from carrier phase, else modulator phase
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     phase_upd;    // advance carrier phase
        logic     out_load;     // move finished sample into output register
    } fmop_cmd_t;

    typedef struct packed {
        logic out_free;
    } fmop_status_t;

    // Sine of a 32-bit turn fraction in Q1.15, by a fixed-point Taylor series
    function automatic logic signed [15:0] sine_from_frac(input logic [63:0] f);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        quad = f[31:30];
        r = {34'd0, f[29:0]};
        u = quad[0] ? (Q30 - r) : r;
        x = (u * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = Q30 - x2 / 72;
        t = Q30 - ((x2 * t) >> 30) / 42;
        t = Q30 - ((x2 * t) >> 30) / 20;
        t = Q30 - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        q = (s + (64'd1 << 14)) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return quad[1] ? -$signed(q[15:0]) : $signed(q[15:0]);
    endfunction

endpackage

/* design/fmop_sine_rom.sv */
// Sine lookup ROM, one full turn in Q1.15, registered read.
// Depends on fmop_pkg for the entry function.
module fmop_sine_rom #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    addr,
    output logic signed [15:0]  data
);
    import fmop_pkg::*;

    logic signed [15:0] rom [DEPTH];
    logic signed [15:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] FRAC = (64'(k) << 32) / DEPTH;
        assign rom[k] = sine_from_frac(FRAC);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

/* design/fmop_datapath.sv */
// Datapath of the FM voice: config registers, phases, shared multiplier,
// sine ROM and output register. Depends on fmop_pkg and fmop_sine_rom.
module fmop_datapath #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fmop_pkg::fmop_cmd_t                cmd,
    output fmop_pkg::fmop_status_t             status,
    input  logic                               cfg_we,
    input  logic [fmop_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fmop_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [31:0]                        s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,
    output logic                               m_tlast
);
    import fmop_pkg::*;

    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_PROD_W = PHASE_BITS + IDX_W + 1;
    localparam int DELTA_SH   = 59 - PHASE_BITS;

    // Configuration
    logic [STEP_W-1:0]  carrier_step_reg;
    logic [STEP_W-1:0]  modulator_step_reg;
    logic [DEPTH_W-1:0] min_depth_reg;
    logic [DEPTH_W-1:0] max_depth_reg;
    logic               follow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_step_reg   <= CARRIER_STEP_RST;
            modulator_step_reg <= MODULATOR_STEP_RST;
            min_depth_reg      <= MIN_DEPTH_RST;
            max_depth_reg      <= MAX_DEPTH_RST;
            follow_reg         <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CARRIER_STEP:   carrier_step_reg   <= cfg_data;
                REG_MODULATOR_STEP: modulator_step_reg <= cfg_data;
                REG_MIN_DEPTH:      min_depth_reg      <= cfg_data[DEPTH_W-1:0];
                REG_MAX_DEPTH:      max_depth_reg      <= cfg_data[DEPTH_W-1:0];
                REG_FOLLOW_CARRIER: follow_reg         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Steps in phase units: step * 2^PHASE_BITS / 2^32
    logic [STEP_W+PHASE_BITS-1:0] cstep_ext;
    logic [STEP_W+PHASE_BITS-1:0] mstep_ext;
    logic [PHASE_BITS-1:0]        cstep_scaled;
    logic [PHASE_BITS-1:0]        mstep_scaled;

    assign cstep_ext    = {carrier_step_reg, {PHASE_BITS{1'b0}}};
    assign mstep_ext    = {modulator_step_reg, {PHASE_BITS{1'b0}}};
    assign cstep_scaled = cstep_ext[STEP_W+PHASE_BITS-1:STEP_W];
    assign mstep_scaled = mstep_ext[STEP_W+PHASE_BITS-1:STEP_W];

    // Input latch
    logic [ENV_W-1:0] cenv_reg;
    logic [ENV_W-1:0] menv_reg;
    logic             end_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cenv_reg <= s_tdata[ENV_W-1:0];
            menv_reg <= follow_reg ? s_tdata[ENV_W-1:0] : s_tdata[2*ENV_W-1:ENV_W];
            end_reg  <= s_tlast;
        end
    end

    // Shared multiplier
    logic [63:0]         prod_reg;
    logic signed [32:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic signed [64:0]  mul_p;
    logic signed [15:0]  sine_q;
    logic [16:0]         diff;
    logic [19:0]         depth_raw;
    logic [15:0]         depth;

    assign diff = {max_depth_reg[15], max_depth_reg} - {min_depth_reg[15], min_depth_reg};

    // depth = min + floor(diff * menv / 2^14), saturated to 16 bits
    assign depth_raw = {{4{min_depth_reg[15]}}, min_depth_reg}
                     + {prod_reg[32], prod_reg[32:14]};
    assign depth = (depth_raw[19:15] == 5'b00000 || depth_raw[19:15] == 5'b11111)
                 ? depth_raw[15:0]
                 : (depth_raw[19] ? 16'h8000 : 16'h7fff);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DEPTH:
            begin
                mul_a = {{16{diff[16]}}, diff};
                mul_b = {{16{menv_reg[15]}}, menv_reg};
            end
            MUL_MSD:
            begin
                mul_a = {{17{sine_q[15]}}, sine_q};
                mul_b = {{16{depth[15]}}, depth};
            end
            MUL_STEP:
            begin
                mul_a = {1'b0, modulator_step_reg};
                mul_b = prod_reg[31:0];
            end
            MUL_OUT:
            begin
                mul_a = {{17{cenv_reg[15]}}, cenv_reg};
                mul_b = {{16{sine_q[15]}}, sine_q};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p[63:0];
        end
    end

    // Phases
    logic [PHASE_BITS-1:0] mod_phase_reg;
    logic [PHASE_BITS-1:0] mod_phase_next;
    logic [PHASE_BITS-1:0] car_phase_reg;
    logic [PHASE_BITS-1:0] car_phase_next;
    logic                  note_clear;

    assign note_clear = cmd.out_load && end_reg;

    always_comb
    begin
        mod_phase_next = mod_phase_reg;
        car_phase_next = car_phase_reg;
        if (cmd.load)
        begin
            mod_phase_next = mod_phase_reg + mstep_scaled;
        end
        if (cmd.phase_upd)
        begin
            car_phase_next = car_phase_reg + cstep_scaled
                           + prod_reg[DELTA_SH +: PHASE_BITS];
        end
        if (note_clear)
        begin
            mod_phase_next = '0;
            car_phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_phase_reg <= '0;
            car_phase_reg <= '0;
        end
        else
        begin
            mod_phase_reg <= mod_phase_next;
            car_phase_reg <= car_phase_next;
        end
    end

    // Table index = floor(phase * depth / 2^PHASE_BITS)
    logic [PHASE_BITS-1:0] rom_phase;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]      rom_addr;

    assign rom_phase = cmd.rom_carrier ? car_phase_reg : mod_phase_reg;
    assign idx_prod  = IDX_PROD_W'(rom_phase) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign rom_addr  = idx_prod[PHASE_BITS +: IDX_W];

    fmop_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_rom (
        .clk   (clk),
        .rd_en (cmd.rom_rd),
        .addr  (rom_addr),
        .data  (sine_q)
    );

    // Output: floor(cenv * sine / 2^14), saturated
    logic [17:0] smp_raw;
    logic [15:0] smp_sat;
    logic        m_tvalid_reg;
    logic [15:0] sample_reg;
    logic        last_reg;

    assign smp_raw = prod_reg[31:14];
    assign smp_sat = (smp_raw[17:15] == 3'b000 || smp_raw[17:15] == 3'b111)
                   ? smp_raw[15:0]
                   : (smp_raw[17] ? 16'h8000 : 16'h7fff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sample_reg <= smp_sat;
            last_reg   <= end_reg;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = sample_reg;
    assign m_tlast  = last_reg;

endmodule

/* design/fmop_ctrl.sv */
// Sequencer of the FM voice: steps one request through the shared
// multiplier and the sine ROM. Depends on fmop_pkg.
module fmop_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  fmop_pkg::fmop_status_t status,
    output fmop_pkg::fmop_cmd_t    cmd
);
    import fmop_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DEPTH  = 8'b0000_0010,
        ST_MSD    = 8'b0000_0100,
        ST_STEP   = 8'b0000_1000,
        ST_PHASE  = 8'b0001_0000,
        ST_READC  = 8'b0010_0000,
        ST_OUTMUL = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.mul_sel = MUL_DEPTH;
        case (state_reg)
            ST_IDLE:
            begin
                // read modulator sine at the old phase while accepting
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cmd.rom_rd = 1'b1;
                    state_next = ST_DEPTH;
                end
            end
            ST_DEPTH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEPTH;
                state_next  = ST_MSD;
            end
            ST_MSD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MSD;
                state_next  = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_STEP;
                state_next  = ST_PHASE;
            end
            ST_PHASE:
            begin
                cmd.phase_upd = 1'b1;
                state_next    = ST_READC;
            end
            ST_READC:
            begin
                cmd.rom_rd      = 1'b1;
                cmd.rom_carrier = 1'b1;
                state_next      = ST_OUTMUL;
            end
            ST_OUTMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_OUT;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register can take the sample
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* design/fm_operator_pair_synth_top.sv */
// Top level of the two-operator FM voice.
// Depends on fmop_pkg, fmop_ctrl and fmop_datapath.
//
//  channel  | direction | carries
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | carrier/modulation envelopes, note end on tlast
//  m_*      | out       | Q1.15 sample, last sample of note on tlast
//  cfg_*    | in        | register writes, no read-back
//
// A request steps through DEPTH, MSD, STEP, PHASE, READC, OUTMUL and DONE, which
// loads its sample into the output register once that is free. Four products
// share one multiplier and the sine ROM has a single read port, read once per
// operator. The output register frees s_tready while a sample waits; a stalled
// m_tready holds the next sample in its last state. Reset clears the phases and
// loads the register defaults; the sine table needs no fill.
module fm_operator_pair_synth_top #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [15:0] carrier_env, [31:16] modulation_env
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [15:0] sample
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [fmop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmop_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fmop_pkg::*;

    fmop_cmd_t    cmd;
    fmop_status_t status;

    fmop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fmop_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* design/fmop_checker.sv */
// Port-level checks for the FM voice, bound to the top level.
// Depends on fm_operator_pair_synth_top only through the bind.
module fmop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // one request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after a request was accepted");

    // the sequencer frees the input only by handing over a sample
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid)
        else $error("input freed without a result in the output register");

    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $rose(s_tready))
        else $error("result appeared while the sequencer stayed busy");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind fm_operator_pair_synth_top fmop_checker u_fmop_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* bench/fmop_sample_checker.sv */
// Sample checker for the two-operator FM voice: watches the request, result
// and register-write channels, predicts each sample and compares it.
// Depends on fmop_pkg for register indexes and port widths.
module fmop_sample_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [15:0] carrier_env, [31:16] modulation_env
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,   // [15:0] sample
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [fmop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmop_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              samples_checked
);
    import fmop_pkg::*;

    localparam int         SINE_DEPTH  = 1024;
    localparam int         SINE_IDX_W  = 10;
    localparam bit [63:0]  ONE_Q30     = 64'd1 << 30;
    localparam bit [63:0]  QUARTER_TAU = 64'd1686629713;   // pi/2 in Q30
    localparam int         PRINT_CAP   = 100;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } voice_sample_t;

    logic signed [15:0] sine_q15 [SINE_DEPTH];

    logic [31:0]        carrier_step_q;
    logic [31:0]        modulator_step_q;
    logic signed [15:0] min_depth_q;
    logic signed [15:0] max_depth_q;
    logic               follow_carrier_q;
    logic [31:0]        mod_phase;
    logic [31:0]        car_phase;

    voice_sample_t expected_samples[$];
    voice_sample_t oldest_sample;

    // Table entry k: sine of k/SINE_DEPTH turn, Taylor series in Q30, rounded to Q1.15
    function automatic logic signed [15:0] sine_entry_q15(input int unsigned k);
        bit [63:0] frac;
        bit [1:0]  quadrant;
        bit [63:0] rem;
        bit [63:0] folded;
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] series;
        bit [63:0] mag;
        bit [63:0] rounded;
        frac = 64'(k) << (32 - SINE_IDX_W);
        quadrant = frac[31:30];
        rem = frac & (ONE_Q30 - 1);
        folded = quadrant[0] ? (ONE_Q30 - rem) : rem;
        x = (folded * QUARTER_TAU) >> 30;
        x2 = (x * x) >> 30;
        series = ONE_Q30 - x2 / 72;
        series = ONE_Q30 - ((x2 * series) >> 30) / 42;
        series = ONE_Q30 - ((x2 * series) >> 30) / 20;
        series = ONE_Q30 - ((x2 * series) >> 30) / 6;
        mag = (x * series) >> 30;
        rounded = (mag + (64'd1 << 14)) >> 15;
        if (rounded > 64'd32767)
        begin
            rounded = 64'd32767;
        end
        return quadrant[1] ? -16'(rounded) : 16'(rounded);
    endfunction

    function automatic logic signed [15:0] clamp_q15(input longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
        begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
        mismatches++;
    endtask

    // Advance both operators by one sample and queue the resulting output
    task automatic predict_voice_sample(input logic signed [15:0] cenv,
                                        input logic signed [15:0] menv_in,
                                        input logic note_end);
        longint        menv;
        longint        mod_sine;
        longint        span;
        longint        depth;
        longint        bend;
        longint        car_sine;
        voice_sample_t predicted;
        menv = follow_carrier_q ? longint'(cenv) : longint'(menv_in);
        mod_sine = sine_q15[mod_phase[31 -: SINE_IDX_W]];
        mod_phase = mod_phase + modulator_step_q;
        span = longint'(max_depth_q) - longint'(min_depth_q);
        depth = clamp_q15(longint'(min_depth_q) + ((span * menv) >>> 14));
        bend = (longint'({32'd0, modulator_step_q}) * (mod_sine * depth)) >>> 27;
        car_phase = car_phase + carrier_step_q + bend[31:0];
        car_sine = sine_q15[car_phase[31 -: SINE_IDX_W]];
        predicted.sample = clamp_q15((longint'(cenv) * car_sine) >>> 14);
        predicted.last = note_end;
        if (note_end)
        begin
            mod_phase = '0;
            car_phase = '0;
        end
        expected_samples.push_back(predicted);
    endtask

    initial
    begin
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            sine_q15[k] = sine_entry_q15(k);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_step_q = CARRIER_STEP_RST;
            modulator_step_q = MODULATOR_STEP_RST;
            min_depth_q = MIN_DEPTH_RST;
            max_depth_q = MAX_DEPTH_RST;
            follow_carrier_q = 1'b1;
            mod_phase = '0;
            car_phase = '0;
            mismatches = 0;
            samples_checked = 0;
            expected_samples.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    report_mismatch($sformatf("sample %h last %b with none expected",
                                              m_tdata, m_tlast));
                end
                else
                begin
                    oldest_sample = expected_samples.pop_front();
                    if (m_tdata !== oldest_sample.sample)
                    begin
                        report_mismatch($sformatf("result %0d: sample %h, want %h",
                                                  samples_checked, m_tdata,
                                                  oldest_sample.sample));
                    end
                    if (m_tlast !== oldest_sample.last)
                    begin
                        report_mismatch($sformatf("result %0d: last %b, want %b",
                                                  samples_checked, m_tlast,
                                                  oldest_sample.last));
                    end
                    samples_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CARRIER_STEP:   carrier_step_q = cfg_data[31:0];
                    REG_MODULATOR_STEP: modulator_step_q = cfg_data[31:0];
                    REG_MIN_DEPTH:      min_depth_q = cfg_data[15:0];
                    REG_MAX_DEPTH:      max_depth_q = cfg_data[15:0];
                    REG_FOLLOW_CARRIER: follow_carrier_q = cfg_data[0];
                    default:            ;   // drop writes to unused indexes
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_voice_sample(s_tdata[15:0], s_tdata[31:16], s_tlast);
            end
        end
        outstanding = expected_samples.size();
    end

endmodule

/* bench/tb_fm_operator_pair_synth_top.sv */
// Testbench top for the two-operator FM voice: clock, reset, register
// settings, note stimulus and output back-pressure, plus the final verdict.
// Depends on fmop_pkg, fm_operator_pair_synth_top and fmop_sample_checker.
module tb_fm_operator_pair_synth_top;
    import fmop_pkg::*;

    localparam int IDLE_LIMIT      = 6000;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES    = 24;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 72;

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_HALF,
        RX_PATTERN
    } rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int samples_checked;

    int       burst_left;
    int       hold_requests;
    int       idle_cycles = 0;
    int       samples_sent;
    int       notes_sent;
    int       settings_used;
    rx_mode_t rx_mode;
    int       rx_count;
    bit [15:0] rx_pattern;

    fm_operator_pair_synth_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fmop_sample_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .samples_checked (samples_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Envelope values: plausible Q2.14 levels, extremes and some noise
    function automatic logic [15:0] pick_env();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            3, 4, 5: return 16'($urandom_range(0, 16384));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    // Drop valid and hold until every queued sample has come out
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait (outstanding == 0);
        repeat (4) @(negedge clk);
    endtask

    // Write all registers; upper bits of the narrow registers carry junk
    task automatic apply_setting(input logic [31:0] car_step, input logic [31:0] mod_incr,
                                 input logic [15:0] min_d, input logic [15:0] max_d,
                                 input logic follow, input bit spare_writes);
        wait_idle();
        write_reg(REG_CARRIER_STEP, car_step);
        write_reg(REG_MODULATOR_STEP, mod_incr);
        write_reg(REG_MIN_DEPTH, {16'($urandom), min_d});
        write_reg(REG_MAX_DEPTH, {16'($urandom), max_d});
        write_reg(REG_FOLLOW_CARRIER, {31'($urandom), follow});
        if (spare_writes)
        begin
            for (int i = int'(REG_FOLLOW_CARRIER) + 1; i < (1 << CFG_IDX_W); i++)
            begin
                write_reg(CFG_IDX_W'(i), $urandom);
            end
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_sample(input logic [15:0] cenv, input logic [15:0] menv,
                               input logic note_end);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {menv, cenv};
        s_tlast <= note_end;
        burst_left--;
        do @(posedge clk); while (!s_tready);
        samples_sent++;
        if (note_end)
        begin
            notes_sent++;
        end
    endtask

    task automatic random_setting();
        logic [31:0] car_step;
        case ($urandom_range(0, 5))
            0:
                apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF,
                              1'($urandom), 1'b1);
            1:
                apply_setting(32'h0, 32'h0, 16'h7FFF, 16'h8000, 1'($urandom), 1'b0);
            2:
                apply_setting($urandom, $urandom, 16'($urandom), 16'($urandom),
                              1'($urandom), 1'($urandom));
            default:
            begin
                // audio-like pitches with a small integer frequency ratio
                car_step = $urandom_range(32'h0010_0000, 32'h1000_0000);
                apply_setting(car_step, car_step * $urandom_range(1, 7),
                              16'($urandom_range(0, 8192)), 16'($urandom_range(0, 32767)),
                              1'($urandom), 1'($urandom));
            end
        endcase
    endtask

    // Output back-pressure, with an occasional long hold requested by the stimulus
    initial
    begin
        int holds_served;
        holds_served = 0;
        m_tready = 1'b0;
        rx_mode = RX_ALWAYS;
        rx_count = 0;
        rx_pattern = 16'h5A3D;
        forever
        begin
            @(negedge clk);
            if (holds_served < hold_requests)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                holds_served++;
            end
            else
            begin
                rx_count++;
                if (rx_count % 211 == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_pattern = 16'($urandom) | 16'h0001;
                end
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                    RX_HALF:   m_tready <= 1'($urandom);
                    default:   m_tready <= rx_pattern[rx_count % 16];
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles, %0d samples outstanding",
                         IDLE_LIMIT, outstanding);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_items;
        int note_len;
        bit end_flag;

        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_requests = 0;
        burst_left = 0;
        samples_sent = 0;
        notes_sent = 0;
        settings_used = 1;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset defaults: envelope extremes, carrier envelope drives depth
        send_sample(16'h7FFF, 16'h0000, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'h0000, 16'h8000, 1'b0);
        send_sample(16'h4000, 16'h1234, 1'b0);
        send_sample(16'hFFFF, 16'h0000, 1'b1);
        send_sample(16'h4000, 16'h0000, 1'b0);

        // Widest depth span, full-scale steps: depth saturates, phases wrap
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 1'b0, 1'b1);
        send_sample(16'h7FFF, 16'h7FFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h7FFF, 16'h0000, 1'b0);
        send_sample(16'h8000, 16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 16'h4000, 1'b0);
        send_sample(16'h7FFF, 16'hC000, 1'b1);

        // Zero steps, reversed depth span
        apply_setting(32'h0, 32'h0, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
        send_sample(16'h7FFF, 16'h5555, 1'b0);
        send_sample(16'h8000, 16'hAAAA, 1'b0);
        send_sample(16'h2000, 16'h0000, 1'b1);

        apply_setting(32'h8000_0000, 32'h4000_0000, 16'h1000, 16'h7000, 1'b0, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h4000, 1'b0);
        send_sample(16'h3FFF, 16'h0001, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b1);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            random_setting();
            // long output stall while requests keep coming, so the input backs up
            if (phase == 2 || phase == 6)
            begin
                hold_requests++;
            end
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                note_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(4, 60);
                for (int n = 0; n < note_len; n++)
                begin
                    end_flag = (n == note_len - 1) || ($urandom_range(0, 31) == 0);
                    send_sample(pick_env(), pick_env(), end_flag);
                    phase_items++;
                end
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d samples in %0d notes over %0d register settings, %0d results checked",
                 samples_sent, notes_sent, settings_used, samples_checked);
        $display("Included saturated depths and samples, phase wrap and long output stalls");
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
